FILE: rtl/aabb_collision_resolver_top_macros.svh
// ----------------------------------------------------------------------------
// aabb collision resolver assertion macros
// shared assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef AABB_COLLISION_RESOLVER_TOP_MACROS_SVH
`define AABB_COLLISION_RESOLVER_TOP_MACROS_SVH

// a implies b in the same cycle
`define ACR_ASSERT_IMP(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");

// a implies b in the next cycle
`define ACR_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");

`endif

FILE: rtl/acr_pkg.sv
// ----------------------------------------------------------------------------
// acr_pkg
// types, constants and command codes of the box collision resolver
// ----------------------------------------------------------------------------
`default_nettype none
package acr_pkg;
    localparam int MaxBoxesDef  = 64;
    localparam int CoordBitsDef = 20;
    localparam int FieldCoord   = 20;
    localparam int FieldSize    = 19;
    localparam int CountBits    = 7;

    localparam logic       CMD_WRITE   = 1'b0;
    localparam logic       CMD_RESOLVE = 1'b1;
    localparam logic [1:0] KIND_SOLID  = 2'd0;
    localparam logic [1:0] KIND_DAMAGE = 2'd1;
    localparam logic [1:0] KIND_LADDER = 2'd2;

    typedef struct packed {
        logic                         cmd;
        logic [5:0]                   box_index;
        logic [1:0]                   box_kind;
        logic signed [FieldCoord-1:0] box_left;
        logic signed [FieldCoord-1:0] box_top;
        logic [FieldSize-1:0]         box_width;
        logic [FieldSize-1:0]         box_height;
        logic signed [FieldCoord-1:0] actor_left;
        logic signed [FieldCoord-1:0] actor_top;
        logic [FieldSize-1:0]         actor_width;
        logic [FieldSize-1:0]         actor_height;
    } in_item_t;

    typedef struct packed {
        logic signed [FieldCoord-1:0] new_left;
        logic signed [FieldCoord-1:0] new_top;
        logic                         stop_x;
        logic                         stop_y;
        logic                         landed;
        logic                         side_hit;
        logic                         in_damage;
        logic                         on_ladder;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_WRITE, ST_P1_RD, ST_P1_EV, ST_P2_RD, ST_P2_EV, ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input item
        logic wr_box;    // write entry
        logic rd;        // issue table read at index
        logic eval1;     // solid pass step
        logic eval2;     // area pass step
        logic clr_idx;
        logic inc_idx;
        logic emit;      // load output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_resolve;
        logic idx_last;  // index reached count
    } stat_t;
endpackage
`default_nettype wire

FILE: rtl/acr_datapath.sv
// ----------------------------------------------------------------------------
// acr_datapath
// box table, actor registers, overlap and push arithmetic
// ----------------------------------------------------------------------------
`default_nettype none
module acr_datapath import acr_pkg::*; #(
    parameter int MAX_BOXES  = MaxBoxesDef,
    parameter int COORD_BITS = CoordBitsDef
) (
    input  wire logic                 aclk,
    input  wire in_item_t             in_item,
    input  wire logic [CountBits-1:0] boxes_in_use,
    input  wire cmd_t                 cmd,
    output stat_t                     stat,
    output out_item_t                 out_item
);
    localparam int IW = $clog2(MAX_BOXES + 1);
    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    // room for a coordinate plus a size on either side
    localparam int W  = ((COORD_BITS > FieldSize) ? COORD_BITS : FieldSize + 1) + 2;
    localparam logic signed [W-1:0] HI = W'((64'sd1 <<< (COORD_BITS - 1)) - 1);
    localparam logic signed [W-1:0] LO = -HI - W'(1);

    logic signed [COORD_BITS-1:0] mem_left [MAX_BOXES];
    logic signed [COORD_BITS-1:0] mem_top  [MAX_BOXES];
    logic [FieldSize-1:0]         mem_w    [MAX_BOXES];
    logic [FieldSize-1:0]         mem_h    [MAX_BOXES];
    logic [1:0]                   mem_kind [MAX_BOXES];

    logic signed [COORD_BITS-1:0] rd_left_reg, rd_top_reg;
    logic [FieldSize-1:0]         rd_w_reg, rd_h_reg;
    logic [1:0]                   rd_kind_reg;
    logic signed [COORD_BITS-1:0] al_reg, at_reg, al_next, at_next;
    logic [FieldSize-1:0]         aw_reg, ah_reg;
    logic                         res_reg;
    logic [IW-1:0]                idx_reg;
    logic [IW-1:0]                n_lim;
    logic sx_reg, sy_reg, land_reg, side_reg, dmg_reg, lad_reg;
    logic sx_next, sy_next, land_next, side_next, dmg_next, lad_next;
    out_item_t out_reg;

    logic signed [W-1:0] al, at, ar, ab, bl, bt, br, bb, ol, orr, ot, ob, mx, my, v;
    logic ovl, from_left, from_top;

    // actual entries visited
    assign n_lim = (32'(boxes_in_use) > MAX_BOXES) ? IW'(MAX_BOXES) : IW'(boxes_in_use);
    assign stat.is_resolve = res_reg;
    assign stat.idx_last   = (idx_reg >= n_lim);
    assign out_item        = out_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_box && 32'(in_item.box_index) < MAX_BOXES) begin
            mem_left[AW'(in_item.box_index)] <= COORD_BITS'(in_item.box_left);
            mem_top[AW'(in_item.box_index)]  <= COORD_BITS'(in_item.box_top);
            mem_w[AW'(in_item.box_index)]    <= in_item.box_width;
            mem_h[AW'(in_item.box_index)]    <= in_item.box_height;
            mem_kind[AW'(in_item.box_index)] <= in_item.box_kind;
        end
        if (cmd.rd) begin
            rd_left_reg <= mem_left[AW'(idx_reg)];
            rd_top_reg  <= mem_top[AW'(idx_reg)];
            rd_w_reg    <= mem_w[AW'(idx_reg)];
            rd_h_reg    <= mem_h[AW'(idx_reg)];
            rd_kind_reg <= mem_kind[AW'(idx_reg)];
        end
    end

    always_comb begin
        al = W'(al_reg);
        at = W'(at_reg);
        ar = al + W'(aw_reg);
        ab = at + W'(ah_reg);
        bl = W'(rd_left_reg);
        bt = W'(rd_top_reg);
        br = bl + W'(rd_w_reg);
        bb = bt + W'(rd_h_reg);
        ovl = ((al > bl) ? al : bl) < ((ar < br) ? ar : br) &&
              ((at > bt) ? at : bt) < ((ab < bb) ? ab : bb);
        ol  = ar - bl;
        orr = br - al;
        ot  = ab - bt;
        ob  = bb - at;
        from_left = ol < orr;
        from_top  = ot < ob;
        mx = from_left ? ol : orr;
        my = from_top ? ot : ob;
        al_next = al_reg; at_next = at_reg;
        sx_next = sx_reg; sy_next = sy_reg; land_next = land_reg; side_next = side_reg;
        dmg_next = dmg_reg; lad_next = lad_reg;
        v = '0;
        if (cmd.eval1 && rd_kind_reg == KIND_SOLID && ovl) begin
            if (mx < my) begin
                v = from_left ? al - ol : al + orr;
                al_next = (v > HI) ? COORD_BITS'(HI) : (v < LO) ? COORD_BITS'(LO)
                                                                 : COORD_BITS'(v);
                sx_next = 1'b1; side_next = 1'b1;
            end else begin
                v = from_top ? at - ot : at + ob;
                at_next = (v > HI) ? COORD_BITS'(HI) : (v < LO) ? COORD_BITS'(LO)
                                                                 : COORD_BITS'(v);
                sy_next = 1'b1;
                if (from_top) land_next = 1'b1;
            end
        end
        if (cmd.eval2 && ovl) begin
            if (rd_kind_reg == KIND_DAMAGE) dmg_next = 1'b1;
            if (rd_kind_reg == KIND_LADDER) lad_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            res_reg <= in_item.cmd;
            al_reg  <= COORD_BITS'(in_item.actor_left);
            at_reg  <= COORD_BITS'(in_item.actor_top);
            aw_reg  <= in_item.actor_width;
            ah_reg  <= in_item.actor_height;
            {sx_reg, sy_reg, land_reg, side_reg, dmg_reg, lad_reg} <= '0;
        end else begin
            al_reg <= al_next; at_reg <= at_next;
            sx_reg <= sx_next; sy_reg <= sy_next; land_reg <= land_next;
            side_reg <= side_next; dmg_reg <= dmg_next; lad_reg <= lad_next;
        end
        if (cmd.clr_idx) idx_reg <= '0;
        else if (cmd.inc_idx) idx_reg <= idx_reg + IW'(1);
        if (cmd.emit) begin
            if (res_reg) begin
                out_reg.new_left  <= FieldCoord'(al_reg);
                out_reg.new_top   <= FieldCoord'(at_reg);
                out_reg.stop_x    <= sx_reg;
                out_reg.stop_y    <= sy_reg;
                out_reg.landed    <= land_reg;
                out_reg.side_hit  <= side_reg;
                out_reg.in_damage <= dmg_reg;
                out_reg.on_ladder <= lad_reg;
            end else begin
                out_reg <= '0;
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/acr_ctrl.sv
// ----------------------------------------------------------------------------
// acr_ctrl
// sequencer for box writes and the two resolve passes
// ----------------------------------------------------------------------------
`default_nettype none
module acr_ctrl import acr_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  wire logic  m_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);
    state_t state_reg, state_next;
    logic   mv_reg, mv_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    assign m_valid = mv_reg;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        mv_next = mv_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    cmd.clr_idx = 1'b1;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (stat.is_resolve) begin
                    state_next = ST_P1_RD;
                end else begin
                    // box writes happen here so the item is registered first
                    cmd.wr_box = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_P1_RD: begin
                if (stat.idx_last) begin
                    cmd.clr_idx = 1'b1;
                    state_next = ST_P2_RD;
                end else begin
                    cmd.rd = 1'b1;
                    cmd.inc_idx = 1'b1;
                    state_next = ST_P1_EV;
                end
            end
            ST_P1_EV: begin
                cmd.eval1 = 1'b1;
                state_next = ST_P1_RD;
            end
            ST_P2_RD: begin
                if (stat.idx_last) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.rd = 1'b1;
                    cmd.inc_idx = 1'b1;
                    state_next = ST_P2_EV;
                end
            end
            ST_P2_EV: begin
                cmd.eval2 = 1'b1;
                state_next = ST_P2_RD;
            end
            ST_OUT: begin
                // wait for the output register to free up
                if (!mv_reg || m_ready) begin
                    cmd.emit = 1'b1;
                    mv_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

FILE: rtl/aabb_collision_resolver_top.sv
// ----------------------------------------------------------------------------
// aabb collision resolver
// box table with minimum-translation push-out of an actor rectangle
// ----------------------------------------------------------------------------
// usage:
//   s_ channel takes one item: a box write (cmd 0) or a resolve (cmd 1).
//   m_ channel returns one item for every input item; box writes return zeros.
//   cfg channel writes boxes_in_use; the user must write it only while
//   the block is idle, which the block itself does not enforce.
// sequencing: a box write goes through ST_WRITE and ST_OUT; a resolve
//   runs two passes over n = min(boxes_in_use, MAX_BOXES) entries, each
//   reading then evaluating one entry at a time over the single read port.
// throughput: one item at a time; s_ready is high in the idle state and
//   stays high while an earlier result waits in the output register.
// reset: aresetn (synchronous, active low) clears the sequencer, the output
//   valid and boxes_in_use; the box table is not cleared.
// stall: while m_ready is low the result holds; a finished next item waits
//   in its last state until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none
module aabb_collision_resolver_top import acr_pkg::*; #(
    parameter int MAX_BOXES  = MaxBoxesDef,
    parameter int COORD_BITS = CoordBitsDef
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_item_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_item_t                 m_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CountBits-1:0] cfg_data
);
    logic [CountBits-1:0] count_reg;
    in_item_t item_reg;
    in_item_t dp_item;
    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cfg_valid) begin
            count_reg <= cfg_data;
        end
        if (cmd.load) item_reg <= s_data;
    end

    // the datapath captures the actor from the port in the accept cycle
    assign dp_item = cmd.load ? s_data : item_reg;

    acr_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .stat, .cmd
    );

    acr_datapath #(.MAX_BOXES(MAX_BOXES), .COORD_BITS(COORD_BITS)) u_dp (
        .aclk, .in_item(dp_item), .boxes_in_use(count_reg),
        .cmd, .stat, .out_item(m_data)
    );
endmodule
`default_nettype wire

FILE: rtl/acr_checker.sv
// ----------------------------------------------------------------------------
// acr_checker
// port-level checks of the resolver handshake and results
// ----------------------------------------------------------------------------
`default_nettype none
`include "aabb_collision_resolver_top_macros.svh"
module acr_checker import acr_pkg::*; (
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);
    `ACR_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `ACR_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `ACR_ASSERT_NEXT(a_no_early_result, aclk, aresetn, s_valid && s_ready, !m_valid || m_ready == 1'b0 || !$rose(m_valid))
    `ACR_ASSERT_IMP(a_land_vertical, aclk, aresetn, m_valid && m_data.landed, m_data.stop_y)
    `ACR_ASSERT_IMP(a_side_x, aclk, aresetn, m_valid, m_data.side_hit == m_data.stop_x)
endmodule
bind aabb_collision_resolver_top acr_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_data
);
`default_nettype wire
